>>> rtl/ewv_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ewma and window volatility block
// depends on nothing

package ewv_pkg;

    localparam int PRICE_W  = 24;
    localparam int TIME_W   = 63;
    localparam int FAIR_W   = 32;
    localparam int VOL_W    = 32;
    localparam int VPS_W    = 40;
    localparam int ALPHA_W  = 17;
    localparam int WIN_W    = 9;
    localparam int CFG_W    = 17;
    localparam int EWMA_W   = 40;
    localparam int FRAC_W   = 16;
    localparam int SQ_W     = 2 * PRICE_W;
    localparam int MPLIER_W = 30;
    localparam int ROOT2_W  = 80;

    localparam logic [ALPHA_W-1:0]  ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0]  ALPHA_RESET = 17'd6554;
    localparam logic [WIN_W-1:0]    WIN_RESET   = 9'd64;
    localparam logic [MPLIER_W-1:0] NS_PER_SEC  = 30'd1000000000;
    localparam logic [VOL_W-1:0]    VOL_MAX     = 32'hFFFF_FFFF;
    localparam logic [VPS_W-1:0]    VPS_MAX     = 40'hFF_FFFF_FFFF;

    typedef enum logic [0:0] {
        CFG_ALPHA  = 1'b0,
        CFG_WINDOW = 1'b1
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EWMA_A,
        ST_EWMA_B,
        ST_SWEEP,
        ST_S1SQ,
        ST_NS2,
        ST_XQ,
        ST_ROOT1,
        ST_DIVN,
        ST_NT,
        ST_PQ,
        ST_DIVP,
        ST_ROOT2,
        ST_DONE
    } state_t;

endpackage

>>> rtl/ewv_ram.sv
`timescale 1ns / 1ps
// generic simple dual port ram, one write and one registered read port
// depends on nothing

module ewv_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

>>> rtl/ewma_and_window_volatility.sv
`timescale 1ns / 1ps
// top level: ewma fair value and rolling volatility of price differences
// depends on ewv_pkg and ewv_ram
//
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    s_price, s_time_ns
// m_        out        m_valid / m_ready    m_fair_value, m_volatility,
//                                           m_volatility_per_second, m_samples_held
// cfg_      in         cfg_wr_en            cfg_index, cfg_wr_data
//
// one tick at a time, worked through by:
// a sweep of the ring memory (one entry per cycle, over the samples held),
// one shared shift-add multiplier (one multiplier bit per cycle), one shared
// restoring divider (one quotient bit per cycle) and one shared square root
// unit (one root bit per cycle)
// reset is synchronous active low; the ring needs no clearing pass
// s_ready is high whenever the sequencer is idle; a finished result waits in the
// output register and stalls only the final step while m_ready is low

module ewma_and_window_volatility #(
    parameter int WINDOW_DEPTH = 256
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [ewv_pkg::PRICE_W-1:0]           s_price,
    input  logic [ewv_pkg::TIME_W-1:0]            s_time_ns,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [ewv_pkg::FAIR_W-1:0]            m_fair_value,
    output logic [ewv_pkg::VOL_W-1:0]             m_volatility,
    output logic [ewv_pkg::VPS_W-1:0]             m_volatility_per_second,
    output logic [$clog2(WINDOW_DEPTH+1)-1:0]     m_samples_held,
    input  logic                                  cfg_wr_en,
    input  logic [0:0]                            cfg_index,
    input  logic [ewv_pkg::CFG_W-1:0]             cfg_wr_data
);

    // widths that follow from the window depth
    localparam int AW   = $clog2(WINDOW_DEPTH);
    localparam int CW   = $clog2(WINDOW_DEPTH + 1);
    localparam int S2W  = ewv_pkg::SQ_W + CW;           // sum of squared differences
    localparam int XW   = ewv_pkg::SQ_W + 2 * CW;       // n*S2 - S1^2
    localparam int QW   = XW + ewv_pkg::FRAC_W;         // 65536*X
    localparam int R1W  = QW / 2;                       // isqrt of Q
    localparam int PW   = QW + ewv_pkg::MPLIER_W;       // Q*1e9, widest operand
    localparam int MW   = CW + ewv_pkg::TIME_W;         // n*T
    localparam int RADW = (QW > ewv_pkg::ROOT2_W) ? QW : ewv_pkg::ROOT2_W;
    localparam int RTW  = RADW / 2;
    localparam int WCMP = (CW > ewv_pkg::WIN_W) ? CW : ewv_pkg::WIN_W;
    localparam int DCW  = $clog2(PW + 1);
    localparam int SCW  = $clog2(RTW + 1);
    localparam int PRW  = ewv_pkg::PRICE_W;
    localparam int TW   = ewv_pkg::TIME_W;

    ewv_pkg::state_t state_reg, state_next;

    // configuration
    logic [ewv_pkg::ALPHA_W-1:0] alpha_reg;
    logic [ewv_pkg::WIN_W-1:0]   win_reg;

    // window bookkeeping
    logic [AW-1:0]              head_reg;
    logic [CW-1:0]              held_reg;
    logic                       seen_reg;
    logic [ewv_pkg::EWMA_W-1:0] ewma_reg;
    logic [PRW-1:0]             price_in_reg;
    logic [TW-1:0]              time_in_reg;

    // ring sweep pipeline: read, difference, square, accumulate
    logic [CW-1:0]        issue_left_reg;
    logic                 first_pend_reg;
    logic [AW-1:0]        rd_addr_reg;
    logic                 rv_reg, rv_first_reg, dv_reg, sqv_reg;
    logic [PRW-1:0]       prev_price_reg;
    logic [TW-1:0]        t_old_reg;
    logic signed [PRW:0]  d_reg;
    logic signed [PRW:0]  s1_reg;
    logic [ewv_pkg::SQ_W-1:0] sq_reg;
    logic [S2W-1:0]       s2_reg;

    // shared shift-add multiplier
    logic [PW-1:0]               acc_reg, mcand_reg;
    logic [ewv_pkg::MPLIER_W-1:0] mplier_reg;

    logic [QW-1:0] q_reg;
    logic [MW-1:0] m_reg;

    // shared restoring divider
    logic [PW-1:0]  num_reg, quo_reg;
    logic [MW-1:0]  den_reg;
    logic [MW:0]    rem_reg;
    logic [DCW-1:0] div_cnt_reg;

    // shared square root unit
    logic [RADW-1:0]  rad_reg;
    logic [RTW+1:0]   srem_reg;
    logic [RTW-1:0]   root_reg;
    logic [SCW-1:0]   sq_cnt_reg;

    logic [ewv_pkg::VOL_W-1:0] vol_reg;
    logic [ewv_pkg::VPS_W-1:0] vps_reg;

    // output register
    logic                      m_valid_reg;
    logic [ewv_pkg::FAIR_W-1:0] m_fair_reg;
    logic [ewv_pkg::VOL_W-1:0]  m_vol_reg;
    logic [ewv_pkg::VPS_W-1:0]  m_vps_reg;
    logic [CW-1:0]             m_held_reg;

    // ring read data
    logic [PRW-1:0] ram_price;
    logic [TW-1:0]  ram_time;

    logic                         accept;
    logic                         rd_issue;
    logic [ewv_pkg::ALPHA_W-1:0]  a_eff;
    logic [CW-1:0]                win_eff, held_inc, held_new, n_val;
    logic [AW-1:0]                head_new, start_addr;
    logic [CW:0]                  start_tmp;
    logic                         sweep_done, out_free, t_pos;

    logic [PW-1:0]   acc_step;
    logic            mul_done;
    logic [MW:0]     rem_sh, rem_new;
    logic            div_ge, div_done;
    logic [RTW+3:0]  srem_sh, trial;
    logic            s_ge, sqrt_done;
    logic [RTW+3:0]  srem_diff;
    logic [XW-1:0]   nsq, x_val;
    logic [PRW:0]    dneg, s1neg;
    logic [PRW-1:0]  dmag, s1mag, mul_a;
    logic [ewv_pkg::SQ_W-1:0] sq_prod;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ewv_pkg::ST_IDLE);
    assign rd_issue = (state_reg == ewv_pkg::ST_SWEEP) && (issue_left_reg != '0);

    // alpha above one acts as one, window clamped to 1..depth
    assign a_eff = (alpha_reg > ewv_pkg::ALPHA_ONE) ? ewv_pkg::ALPHA_ONE : alpha_reg;

    always_comb begin
        if (win_reg == '0) begin
            win_eff = CW'(1);
        end else if (WCMP'(win_reg) > WCMP'(WINDOW_DEPTH)) begin
            win_eff = CW'(WINDOW_DEPTH);
        end else begin
            win_eff = CW'(win_reg);
        end
    end

    // window occupancy and oldest slot after this tick is written
    assign held_inc = (held_reg == CW'(WINDOW_DEPTH)) ? held_reg : held_reg + CW'(1);
    assign held_new = (held_inc > win_eff) ? win_eff : held_inc;
    assign head_new = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + AW'(1);

    always_comb begin
        start_tmp = (CW+1)'(head_new) + (CW+1)'(WINDOW_DEPTH) - (CW+1)'(held_new);
        if (start_tmp >= (CW+1)'(WINDOW_DEPTH)) begin
            start_tmp = start_tmp - (CW+1)'(WINDOW_DEPTH);
        end
        start_addr = AW'(start_tmp);
    end

    assign n_val      = held_reg - CW'(1);
    assign sweep_done = (issue_left_reg == '0) && !rv_reg && !dv_reg && !sqv_reg;
    assign out_free   = !m_valid_reg || m_ready;
    assign t_pos      = time_in_reg > t_old_reg;

    // multiplier step: one multiplier bit per cycle
    assign acc_step = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;
    assign mul_done = (mplier_reg == '0);

    // divider step: one quotient bit per cycle
    assign rem_sh   = {rem_reg[MW-1:0], num_reg[PW-1]};
    assign div_ge   = rem_sh >= {1'b0, den_reg};
    assign rem_new  = div_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
    assign div_done = (div_cnt_reg == '0);

    // square root step: two radicand bits in, one root bit out per cycle
    assign srem_sh   = {srem_reg, rad_reg[RADW-1 -: 2]};
    assign trial     = {2'b00, root_reg, 2'b01};
    assign s_ge      = srem_sh >= trial;
    assign srem_diff = s_ge ? srem_sh - trial : srem_sh;
    assign sqrt_done = (sq_cnt_reg == '0);

    // variance numerator, clamped at zero
    assign nsq   = acc_reg[XW-1:0];
    assign x_val = (nsq >= XW'(sq_reg)) ? nsq - XW'(sq_reg) : '0;

    // one squarer, shared by the sweep and by S1^2
    assign dneg    = -d_reg;
    assign s1neg   = -s1_reg;
    assign dmag    = d_reg[PRW] ? dneg[PRW-1:0] : d_reg[PRW-1:0];
    assign s1mag   = s1_reg[PRW] ? s1neg[PRW-1:0] : s1_reg[PRW-1:0];
    assign mul_a   = (state_reg == ewv_pkg::ST_S1SQ) ? s1mag : dmag;
    assign sq_prod = mul_a * mul_a;

    ewv_ram #(
        .WIDTH (PRW),
        .DEPTH (WINDOW_DEPTH)
    ) u_price_ring (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (head_reg),
        .wr_data (s_price),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_price)
    );

    ewv_ram #(
        .WIDTH (TW),
        .DEPTH (WINDOW_DEPTH)
    ) u_time_ring (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (head_reg),
        .wr_data (s_time_ns),
        .rd_en   (rd_issue),
        .rd_addr (rd_addr_reg),
        .rd_data (ram_time)
    );

    // sequencer state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ewv_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // sequencer next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ewv_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = seen_reg ? ewv_pkg::ST_EWMA_A : ewv_pkg::ST_SWEEP;
                end
            end
            ewv_pkg::ST_EWMA_A: begin
                if (mul_done) state_next = ewv_pkg::ST_EWMA_B;
            end
            ewv_pkg::ST_EWMA_B: begin
                if (mul_done) state_next = ewv_pkg::ST_SWEEP;
            end
            ewv_pkg::ST_SWEEP: begin
                if (sweep_done) begin
                    state_next = (held_reg == CW'(1)) ? ewv_pkg::ST_DONE : ewv_pkg::ST_S1SQ;
                end
            end
            ewv_pkg::ST_S1SQ: state_next = ewv_pkg::ST_NS2;
            ewv_pkg::ST_NS2: begin
                if (mul_done) state_next = ewv_pkg::ST_XQ;
            end
            ewv_pkg::ST_XQ: state_next = ewv_pkg::ST_ROOT1;
            ewv_pkg::ST_ROOT1: begin
                if (sqrt_done) state_next = ewv_pkg::ST_DIVN;
            end
            ewv_pkg::ST_DIVN: begin
                if (div_done) state_next = t_pos ? ewv_pkg::ST_NT : ewv_pkg::ST_DONE;
            end
            ewv_pkg::ST_NT: begin
                if (mul_done) state_next = ewv_pkg::ST_PQ;
            end
            ewv_pkg::ST_PQ: begin
                if (mul_done) state_next = ewv_pkg::ST_DIVP;
            end
            ewv_pkg::ST_DIVP: begin
                if (div_done) begin
                    state_next = (quo_reg[PW-1:ewv_pkg::ROOT2_W] != '0) ?
                                 ewv_pkg::ST_DONE : ewv_pkg::ST_ROOT2;
                end
            end
            ewv_pkg::ST_ROOT2: begin
                if (sqrt_done) state_next = ewv_pkg::ST_DONE;
            end
            ewv_pkg::ST_DONE: begin
                if (out_free) state_next = ewv_pkg::ST_IDLE;
            end
            default: state_next = ewv_pkg::ST_IDLE;
        endcase
    end

    // control state: configuration, window bookkeeping, sweep flags, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg      <= ewv_pkg::ALPHA_RESET;
            win_reg        <= ewv_pkg::WIN_RESET;
            head_reg       <= '0;
            held_reg       <= '0;
            seen_reg       <= 1'b0;
            issue_left_reg <= '0;
            first_pend_reg <= 1'b0;
            rv_reg         <= 1'b0;
            rv_first_reg   <= 1'b0;
            dv_reg         <= 1'b0;
            sqv_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (ewv_pkg::cfg_index_t'(cfg_index))
                    ewv_pkg::CFG_ALPHA:  alpha_reg <= cfg_wr_data[ewv_pkg::ALPHA_W-1:0];
                    ewv_pkg::CFG_WINDOW: win_reg   <= cfg_wr_data[ewv_pkg::WIN_W-1:0];
                    default: ;
                endcase
            end

            if (accept) begin
                head_reg       <= head_new;
                held_reg       <= held_new;
                seen_reg       <= 1'b1;
                issue_left_reg <= held_new;
                first_pend_reg <= 1'b1;
            end else if (rd_issue) begin
                issue_left_reg <= issue_left_reg - CW'(1);
                first_pend_reg <= 1'b0;
            end

            rv_reg       <= rd_issue;
            rv_first_reg <= rd_issue && first_pend_reg;
            dv_reg       <= rv_reg && !rv_first_reg;
            sqv_reg      <= dv_reg;

            if ((state_reg == ewv_pkg::ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        // sweep pipeline runs from its own valid flags
        if (rd_issue) begin
            rd_addr_reg <= (rd_addr_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : rd_addr_reg + AW'(1);
        end
        if (rv_reg) begin
            prev_price_reg <= ram_price;
            if (rv_first_reg) begin
                t_old_reg <= ram_time;
            end else begin
                d_reg <= $signed({1'b0, ram_price}) - $signed({1'b0, prev_price_reg});
            end
        end
        if (dv_reg || (state_reg == ewv_pkg::ST_S1SQ)) begin
            sq_reg <= sq_prod;
        end
        if (dv_reg) begin
            s1_reg <= s1_reg + d_reg;
        end
        if (sqv_reg) begin
            s2_reg <= s2_reg + S2W'(sq_reg);
        end

        case (state_reg)
            ewv_pkg::ST_IDLE: begin
                if (accept) begin
                    price_in_reg <= s_price;
                    time_in_reg  <= s_time_ns;
                    rd_addr_reg  <= start_addr;
                    s1_reg       <= '0;
                    s2_reg       <= '0;
                    // first price seeds the average, otherwise start alpha*price
                    if (!seen_reg) begin
                        ewma_reg <= {s_price, {ewv_pkg::FRAC_W{1'b0}}};
                    end
                    acc_reg    <= '0;
                    mcand_reg  <= PW'({s_price, {ewv_pkg::FRAC_W{1'b0}}});
                    mplier_reg <= ewv_pkg::MPLIER_W'(a_eff);
                end
            end
            ewv_pkg::ST_EWMA_A: begin
                if (!mul_done) begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end else begin
                    // keep the partial sum, add (1 - alpha) * average
                    mcand_reg  <= PW'(ewma_reg);
                    mplier_reg <= ewv_pkg::MPLIER_W'(ewv_pkg::ALPHA_ONE - a_eff);
                end
            end
            ewv_pkg::ST_EWMA_B: begin
                if (!mul_done) begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end else begin
                    ewma_reg <= acc_reg[ewv_pkg::EWMA_W+ewv_pkg::FRAC_W-1:ewv_pkg::FRAC_W];
                end
            end
            ewv_pkg::ST_SWEEP: begin
                if (sweep_done && (held_reg == CW'(1))) begin
                    vol_reg <= '0;
                    vps_reg <= '0;
                end
            end
            ewv_pkg::ST_S1SQ: begin
                acc_reg    <= '0;
                mcand_reg  <= PW'(s2_reg);
                mplier_reg <= ewv_pkg::MPLIER_W'(n_val);
            end
            ewv_pkg::ST_NS2: begin
                if (!mul_done) begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end
            end
            ewv_pkg::ST_XQ: begin
                q_reg      <= {x_val, {ewv_pkg::FRAC_W{1'b0}}};
                rad_reg    <= RADW'({x_val, {ewv_pkg::FRAC_W{1'b0}}}) << (RADW - QW);
                srem_reg   <= '0;
                root_reg   <= '0;
                sq_cnt_reg <= SCW'(R1W);
            end
            ewv_pkg::ST_ROOT1: begin
                if (!sqrt_done) begin
                    rad_reg    <= rad_reg << 2;
                    srem_reg   <= srem_diff[RTW+1:0];
                    root_reg   <= {root_reg[RTW-2:0], s_ge};
                    sq_cnt_reg <= sq_cnt_reg - SCW'(1);
                end else begin
                    // isqrt(Q) / n gives the deviation
                    num_reg     <= PW'(root_reg[R1W-1:0]) << (PW - R1W);
                    den_reg     <= MW'(n_val);
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    div_cnt_reg <= DCW'(R1W);
                end
            end
            ewv_pkg::ST_DIVN: begin
                if (!div_done) begin
                    num_reg     <= num_reg << 1;
                    rem_reg     <= rem_new;
                    quo_reg     <= {quo_reg[PW-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                end else begin
                    vol_reg <= (quo_reg[PW-1:ewv_pkg::VOL_W] != '0) ?
                               ewv_pkg::VOL_MAX : quo_reg[ewv_pkg::VOL_W-1:0];
                    if (t_pos) begin
                        acc_reg    <= '0;
                        mcand_reg  <= PW'(time_in_reg - t_old_reg);
                        mplier_reg <= ewv_pkg::MPLIER_W'(n_val);
                    end else begin
                        vps_reg <= '0;
                    end
                end
            end
            ewv_pkg::ST_NT: begin
                if (!mul_done) begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end else begin
                    m_reg      <= acc_reg[MW-1:0];
                    acc_reg    <= '0;
                    mcand_reg  <= PW'(q_reg);
                    mplier_reg <= ewv_pkg::NS_PER_SEC;
                end
            end
            ewv_pkg::ST_PQ: begin
                if (!mul_done) begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                end else begin
                    num_reg     <= acc_reg;
                    den_reg     <= m_reg;
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                    div_cnt_reg <= DCW'(PW);
                end
            end
            ewv_pkg::ST_DIVP: begin
                if (!div_done) begin
                    num_reg     <= num_reg << 1;
                    rem_reg     <= rem_new;
                    quo_reg     <= {quo_reg[PW-2:0], div_ge};
                    div_cnt_reg <= div_cnt_reg - DCW'(1);
                end else if (quo_reg[PW-1:ewv_pkg::ROOT2_W] != '0) begin
                    // root would not fit in 40 bits
                    vps_reg <= ewv_pkg::VPS_MAX;
                end else begin
                    rad_reg    <= RADW'(quo_reg[ewv_pkg::ROOT2_W-1:0]) << (RADW - ewv_pkg::ROOT2_W);
                    srem_reg   <= '0;
                    root_reg   <= '0;
                    sq_cnt_reg <= SCW'(ewv_pkg::ROOT2_W / 2);
                end
            end
            ewv_pkg::ST_ROOT2: begin
                if (!sqrt_done) begin
                    rad_reg    <= rad_reg << 2;
                    srem_reg   <= srem_diff[RTW+1:0];
                    root_reg   <= {root_reg[RTW-2:0], s_ge};
                    sq_cnt_reg <= sq_cnt_reg - SCW'(1);
                end else begin
                    vps_reg <= root_reg[ewv_pkg::VPS_W-1:0];
                end
            end
            ewv_pkg::ST_DONE: begin
                if (out_free) begin
                    m_fair_reg <= ewma_reg[ewv_pkg::EWMA_W-1:ewv_pkg::EWMA_W-ewv_pkg::FAIR_W];
                    m_vol_reg  <= vol_reg;
                    m_vps_reg  <= vps_reg;
                    m_held_reg <= held_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_valid                 = m_valid_reg;
    assign m_fair_value            = m_fair_reg;
    assign m_volatility            = m_vol_reg;
    assign m_volatility_per_second = m_vps_reg;
    assign m_samples_held          = m_held_reg;

    // a transfer in always leaves at least one price in the window
    a_held_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (held_reg != '0))
        else $error("window empty after an input transfer");

    // a result appears only from the final step
    a_valid_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ewv_pkg::ST_DONE))
        else $error("result valid raised outside the final step");

    // ring read address stays inside the ring for any depth
    a_rd_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_issue |-> ((AW+1)'(rd_addr_reg) < (AW+1)'(WINDOW_DEPTH)))
        else $error("ring read address beyond depth");

    // divider remainder stays below the divisor
    a_rem_below_den: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ewv_pkg::ST_DIVP) || (state_reg == ewv_pkg::ST_DIVN)) |->
        (rem_reg < {1'b0, den_reg}))
        else $error("divider remainder not below divisor");

endmodule

>>> test/tb_ewma_and_window_volatility.sv
`timescale 1ns / 1ps
// testbench for ewma_and_window_volatility: directed table of ticks, then random
// phases under several alpha / window settings, checked against typed-in results or a local predictor
// depends on ewv_pkg and the ewma_and_window_volatility rtl

module tb_ewma_and_window_volatility;
    import ewv_pkg::*;

    localparam int DEPTH      = 256;
    localparam int WATCHDOG   = 10000;
    localparam int LONG_HOLD  = 3000;
    localparam int N_DIRECTED = 18;
    localparam int N_PHASES   = 8;
    localparam int PER_PHASE  = 192;

    // one expected result transfer
    typedef struct {
        logic [FAIR_W-1:0] fair;
        logic [VOL_W-1:0]  vol;
        logic [VPS_W-1:0]  vps;
        logic [WIN_W-1:0]  held;
    } tick_stats_t;

    // one directed tick, with its result typed in where it is obvious
    typedef struct {
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  tns;
        bit                 typed;
        tick_stats_t        stats;
    } tick_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [PRICE_W-1:0]     s_price = '0;
    logic [TIME_W-1:0]      s_time_ns = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [FAIR_W-1:0]      m_fair_value;
    logic [VOL_W-1:0]       m_volatility;
    logic [VPS_W-1:0]       m_volatility_per_second;
    logic [WIN_W-1:0]       m_samples_held;
    logic                   cfg_wr_en = 1'b0;
    logic [0:0]             cfg_index = CFG_ALPHA;
    logic [CFG_W-1:0]       cfg_wr_data = '0;

    always #6 aclk = ~aclk;

    ewma_and_window_volatility i_dut (
        .aclk                    (aclk),
        .aresetn                 (aresetn),
        .s_valid                 (s_valid),
        .s_ready                 (s_ready),
        .s_price                 (s_price),
        .s_time_ns               (s_time_ns),
        .m_valid                 (m_valid),
        .m_ready                 (m_ready),
        .m_fair_value            (m_fair_value),
        .m_volatility            (m_volatility),
        .m_volatility_per_second (m_volatility_per_second),
        .m_samples_held          (m_samples_held),
        .cfg_wr_en               (cfg_wr_en),
        .cfg_index               (cfg_index),
        .cfg_wr_data             (cfg_wr_data)
    );

    // ------------------------------------------------------------------
    // predictor state: its own copy of the window, ewma and registers
    // ------------------------------------------------------------------
    logic [PRICE_W-1:0]  win_price [DEPTH];
    logic [TIME_W-1:0]   win_time  [DEPTH];
    int                  win_head = 0;
    int                  win_held = 0;
    logic [63:0]         fair_q16 = '0;
    bit                  seeded = 1'b0;
    logic [ALPHA_W-1:0]  alpha_reg = ALPHA_RESET;
    logic [WIN_W-1:0]    window_reg = WIN_RESET;

    tick_stats_t         pending_stats [$];
    bit                  failed = 1'b0;

    // driver-side flags, moved with nonblocking assignments so the monitor sees
    // the values that belong to the transfer at that edge
    bit                  row_typed = 1'b0;
    tick_stats_t         row_stats;

    bit                  idle_on = 1'b1;
    bit                  rx_idle = 1'b1;
    bit                  hold_req = 1'b0;
    logic [TIME_W-1:0]   last_tns = '0;
    logic [PRICE_W-1:0]  last_price = '0;

    // largest s in [0, maxv] with s*s*m <= q
    function automatic logic [63:0] root_search(input logic [255:0] q, input logic [255:0] m,
                                                input logic [63:0] maxv);
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  mid;
        logic [255:0] sw;
        lo = '0;
        hi = maxv;
        while (lo < hi) begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            sw  = {192'd0, mid};
            if (sw * sw * m <= q) lo = mid;
            else hi = mid - 64'd1;
        end
        return lo;
    endfunction

    // ewma update, window push and volatility of consecutive differences
    function automatic tick_stats_t tick_stats(input logic [PRICE_W-1:0] price,
                                               input logic [TIME_W-1:0] tns);
        tick_stats_t r;
        logic [63:0]  a;
        int           w;
        int           first;
        int           n;
        longint       d;
        longint       s1;
        logic [63:0]  s2;
        logic [63:0]  mag;
        logic [255:0] x;
        logic [255:0] sq;
        logic [255:0] qv;
        logic [TIME_W-1:0] t_new;
        logic [TIME_W-1:0] t_old;
        a = (alpha_reg > ALPHA_ONE) ? 64'd65536 : {47'd0, alpha_reg};
        w = int'(window_reg);
        if (w < 1) w = 1;
        if (w > DEPTH) w = DEPTH;

        if (!seeded) begin
            fair_q16 = {40'd0, price} << 16;
            seeded = 1'b1;
        end else begin
            fair_q16 = (a * ({40'd0, price} << 16) + (64'd65536 - a) * fair_q16) >> 16;
            fair_q16 = fair_q16 & 64'hFF_FFFF_FFFF;
        end

        win_price[win_head] = price;
        win_time[win_head]  = tns;
        win_head = (win_head + 1) % DEPTH;
        if (win_held < DEPTH) win_held++;
        if (win_held > w) win_held = w;

        first = (win_head + DEPTH - win_held) % DEPTH;
        s1 = 0;
        s2 = '0;
        for (int k = 1; k < win_held; k++) begin
            d = longint'(win_price[(first + k) % DEPTH])
              - longint'(win_price[(first + k - 1) % DEPTH]);
            s1 += d;
            s2 += 64'(d * d);
        end

        r.fair = fair_q16[39:8];
        r.vol  = '0;
        r.vps  = '0;
        r.held = WIN_W'(win_held);
        n = win_held - 1;
        if (n >= 1) begin
            mag = (s1 < 0) ? 64'(-s1) : 64'(s1);
            x   = 256'(n) * {192'd0, s2};
            sq  = {192'd0, mag} * {192'd0, mag};
            x   = (x >= sq) ? x - sq : '0;
            qv  = x << 16;
            r.vol = VOL_W'(root_search(qv, 256'(n) * 256'(n), 64'hFFFF_FFFF));
            t_new = win_time[(win_head + DEPTH - 1) % DEPTH];
            t_old = win_time[first];
            if (t_new > t_old)
                r.vps = VPS_W'(root_search(qv * 256'd1000000000,
                                           256'(n) * {193'd0, t_new - t_old},
                                           64'hFF_FFFF_FFFF));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // monitor: predicts on each input transfer, checks each result transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        tick_stats_t want;
        tick_stats_t got;
        if (aresetn) begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_ALPHA) alpha_reg = cfg_wr_data[ALPHA_W-1:0];
                else window_reg = cfg_wr_data[WIN_W-1:0];
            end
            if (s_valid && s_ready) begin
                want = tick_stats(s_price, s_time_ns);
                // typed rows stand on their own, the predictor only keeps its state
                pending_stats.push_back(row_typed ? row_stats : want);
            end
            if (m_valid && m_ready) begin
                got.fair = m_fair_value;
                got.vol  = m_volatility;
                got.vps  = m_volatility_per_second;
                got.held = m_samples_held;
                if (pending_stats.size() == 0) begin
                    $display("%t unexpected result transfer: fair %0d vol %0d vps %0d held %0d",
                             $time, got.fair, got.vol, got.vps, got.held);
                    failed = 1'b1;
                end else begin
                    want = pending_stats.pop_front();
                    if (got.fair !== want.fair) begin
                        $display("%t fair_value expected %0d actual %0d",
                                 $time, want.fair, got.fair);
                        failed = 1'b1;
                    end
                    if (got.vol !== want.vol) begin
                        $display("%t volatility expected %0d actual %0d",
                                 $time, want.vol, got.vol);
                        failed = 1'b1;
                    end
                    if (got.vps !== want.vps) begin
                        $display("%t volatility_per_second expected %0d actual %0d",
                                 $time, want.vps, got.vps);
                        failed = 1'b1;
                    end
                    if (got.held !== want.held) begin
                        $display("%t samples_held expected %0d actual %0d",
                                 $time, want.held, got.held);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    // watchdog: cycles without any transfer on either channel
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_req = 1'b0;
            end else if (rx_idle && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // offer one tick and hold it until the transfer
    task automatic send_tick(input logic [PRICE_W-1:0] price, input logic [TIME_W-1:0] tns,
                             input bit typed, input tick_stats_t stats);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 15) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_price   <= price;
        s_time_ns <= tns;
        row_typed <= typed;
        row_stats <= stats;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        last_price = price;
        last_tns   = tns;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // lower valid and wait until every result has come back
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // mostly small walks with rising time, some jumps, extremes and time going back
    task automatic random_tick(output logic [PRICE_W-1:0] price,
                               output logic [TIME_W-1:0] tns);
        int step;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                step  = $urandom_range(0, 512) - 256;
                price = PRICE_W'(int'(last_price) + step);
                if (step < 0 && int'(last_price) < -step) price = '0;
                if (step > 0 && int'(last_price) + step > 24'hFF_FFFF) price = '1;
            end
            6:       price = PRICE_W'($urandom);
            7:       price = '0;
            8:       price = '1;
            default: price = PRICE_W'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: tns = last_tns + TIME_W'($urandom_range(1, 1000000));
            7:       tns = last_tns;
            8:       tns = {$urandom, $urandom};
            default: tns = last_tns + {23'd0, 8'($urandom), $urandom};
        endcase
    endtask

    tick_row_t directed_rows [N_DIRECTED] = '{
        // first price seeds the average
        '{24'd100, 63'd1000, 1'b1, '{32'd25600, 32'd0, 40'd0, 9'd1}},
        // same price, no elapsed time
        '{24'd100, 63'd1000, 1'b1, '{32'd25600, 32'd0, 40'd0, 9'd2}},
        '{24'd100, 63'd2000, 1'b1, '{32'd25600, 32'd0, 40'd0, 9'd3}},
        '{24'd0,        63'd3000, 1'b0, '{0, 0, 0, 0}},
        '{24'hFF_FFFF,  63'd3001, 1'b0, '{0, 0, 0, 0}},
        '{24'd0,        63'd3002, 1'b0, '{0, 0, 0, 0}},
        '{24'hFF_FFFF,  63'd3003, 1'b0, '{0, 0, 0, 0}},
        '{24'd0,        63'd3004, 1'b0, '{0, 0, 0, 0}},
        '{24'hFF_FFFF,  63'h7FFF_FFFF_FFFF_FFFF, 1'b0, '{0, 0, 0, 0}},
        '{24'hAA_AAAA,  63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '{0, 0, 0, 0}},
        '{24'h55_5555,  63'h5555_5555_5555_5555, 1'b0, '{0, 0, 0, 0}},
        '{24'd1,        63'd0, 1'b0, '{0, 0, 0, 0}},
        '{24'd2,        63'd0, 1'b0, '{0, 0, 0, 0}},
        '{24'd3,        63'd5, 1'b0, '{0, 0, 0, 0}},
        '{24'd5000,     63'd1000000000, 1'b0, '{0, 0, 0, 0}},
        '{24'd4990,     63'd2000000000, 1'b0, '{0, 0, 0, 0}},
        '{24'd5010,     63'd2000000001, 1'b0, '{0, 0, 0, 0}},
        '{24'd5000,     63'd3000000000, 1'b0, '{0, 0, 0, 0}}
    };

    // alpha and window per random phase; first phase keeps the reset values
    logic [CFG_W-1:0] phase_alpha  [N_PHASES] = '{17'd6554, 17'd65536, 17'd0, 17'h1FFFF,
                                                  17'd70000, 17'd1, 17'd32768, 17'd6554};
    logic [CFG_W-1:0] phase_window [N_PHASES] = '{17'd64, 17'd256, 17'd1, 17'd0,
                                                  17'd511, 17'd2, 17'd300, 17'd8};

    initial begin
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  tns;
        tick_stats_t        none;
        none = '{0, 0, 0, 0};
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_tick(directed_rows[i].price, directed_rows[i].tns,
                      directed_rows[i].typed, directed_rows[i].stats);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p > 0) begin
                drain();
                write_reg(CFG_ALPHA, phase_alpha[p]);
                write_reg(CFG_WINDOW, phase_window[p]);
            end
            // last phase runs with no idling on either side
            if (p == N_PHASES - 1) begin
                idle_on = 1'b0;
                rx_idle = 1'b0;
            end
            for (int i = 0; i < PER_PHASE; i++) begin
                if (p == 1 && i == 20) hold_req = 1'b1;
                random_tick(price, tns);
                send_tick(price, tns, 1'b0, none);
            end
        end
        drain();
        repeat (700) @(posedge aclk);
        if (!failed && pending_stats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ewv_pkg.sv
rtl/ewv_ram.sv
rtl/ewma_and_window_volatility.sv
test/tb_ewma_and_window_volatility.sv
